@@ sv/dirpf_pkg.sv @@
// Shared widths and fixed-point constants of the dual infrared range fusion block.
package dirpf_pkg;
   localparam int SAMPLE_W  = 10;
   localparam int COEF_W    = 32;
   localparam int COEF_SLOTS = 4;
   localparam int LANES     = 2;
   localparam int ADDR_W    = 5;
   localparam int SUM_W     = 64;
   localparam int SQ_W      = 2 * SAMPLE_W;
   localparam int CUBE_W    = 3 * SAMPLE_W;
   localparam int P1_W      = COEF_W + SAMPLE_W + 1;
   localparam int P2_W      = COEF_W + SQ_W + 1;
   localparam int P3_W      = COEF_W + CUBE_W + 1;

   localparam logic signed [SUM_W-1:0] FAR_LIMIT  = 64'sd40 <<< 16;
   localparam logic signed [SUM_W-1:0] NEAR_LIMIT = 64'sd65 <<< 16;
   localparam logic signed [SUM_W-1:0] DIST_MAX   = 64'sd2147483647;
   localparam logic signed [SUM_W-1:0] DIST_MIN   = -64'sd2147483648;

   localparam logic LANE_NEAR = 1'b0;
   localparam logic LANE_FAR  = 1'b1;
endpackage

@@ sv/dual_ir_range_poly_fusion.sv @@
// Dual infrared range sensor calibration and threshold fusion, pipelined.
//
// Input channel: a pair of raw ADC words (req_near_sample, req_far_sample) is
// taken at each rising edge with start high and busy low. busy stays low, so a
// new pair may enter every cycle.
// Each sample is scaled by 2^-ADC_BITS and run through its own cubic
// calibration polynomial (first NUM_COEFS terms, Q15.16 coefficients).
// Far distance below 40 wins, else near distance above 65, else the mean.
// The result is saturated to Q15.16 and shown on rsp_distance for one cycle
// with rsp_valid high.
// Throughput is one pair per cycle; seven register stages (squares, products,
// rounding sums, selection, clamp) each hold one pair in flight.
// The receiver cannot stall; results leave on the fixed schedule.
// Coefficients live at byte addresses 4*i of the APB port (near 0..3, far
// 4..7), read back on prdata; pready is always high. Write them only while
// the pipeline is empty.
// Synchronous reset clears all coefficients to zero and empties the pipeline.
module dual_ir_range_poly_fusion
   import dirpf_pkg::*;
#(
   parameter int ADC_BITS  = 10,
   parameter int NUM_COEFS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ADDR_W-1:0]          paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   input  logic                       start,
   output logic                       busy,
   input  logic [SAMPLE_W-1:0]        req_near_sample,
   input  logic [SAMPLE_W-1:0]        req_far_sample,
   output logic                       rsp_valid,
   output logic signed [COEF_W-1:0]   rsp_distance
);

   localparam int K1 = ADC_BITS;
   localparam int K2 = 2 * ADC_BITS;
   localparam int K3 = 3 * ADC_BITS;
   localparam logic signed [SUM_W-1:0] HALF1 = 64'sd1 <<< (K1 - 1);
   localparam logic signed [SUM_W-1:0] HALF2 = 64'sd1 <<< (K2 - 1);
   localparam logic signed [SUM_W-1:0] HALF3 = 64'sd1 <<< (K3 - 1);
   localparam logic USE1 = NUM_COEFS > 1;
   localparam logic USE2 = NUM_COEFS > 2;
   localparam logic USE3 = NUM_COEFS > 3;

   logic signed [COEF_W-1:0]   coef_ff [LANES][COEF_SLOTS];
   logic                       wr_en;

   logic [6:0]                 v_ff;
   logic [6:0]                 v_in;

   logic [SAMPLE_W-1:0]        s_ff     [LANES];
   logic [SAMPLE_W-1:0]        s_in     [LANES];
   logic [SAMPLE_W-1:0]        s2_ff    [LANES];
   logic [SQ_W-1:0]            sq_ff    [LANES];
   logic [SQ_W-1:0]            sq_in    [LANES];
   logic [CUBE_W-1:0]          cube_ff  [LANES];
   logic [CUBE_W-1:0]          cube_in  [LANES];
   logic signed [P1_W-1:0]     p1_ff    [LANES];
   logic signed [P1_W-1:0]     p1_in    [LANES];
   logic signed [P2_W-1:0]     p2_ff    [LANES];
   logic signed [P2_W-1:0]     p2_in    [LANES];
   logic signed [P3_W-1:0]     p3_ff    [LANES];
   logic signed [P3_W-1:0]     p3_in    [LANES];
   logic signed [SUM_W-1:0]    part_ff  [LANES];
   logic signed [SUM_W-1:0]    part_in  [LANES];
   logic signed [SUM_W-1:0]    dist_ff  [LANES];
   logic signed [SUM_W-1:0]    dist_in  [LANES];
   logic signed [SUM_W-1:0]    t1       [LANES];
   logic signed [SUM_W-1:0]    t2       [LANES];
   logic signed [SUM_W-1:0]    t3       [LANES];

   logic signed [SUM_W-1:0]    sel_ff;
   logic signed [SUM_W-1:0]    sel_in;
   logic signed [SUM_W-1:0]    pair_sum;
   logic signed [COEF_W-1:0]   out_ff;
   logic signed [COEF_W-1:0]   out_in;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign wr_en  = psel && penable && pwrite;
   assign prdata = coef_ff[paddr[ADDR_W-1]][paddr[3:2]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ln = 0; ln < LANES; ln++) begin
            for (int i = 0; i < COEF_SLOTS; i++) begin
               coef_ff[ln][i] <= '0;
            end
         end
      end else if (wr_en) begin
         coef_ff[paddr[ADDR_W-1]][paddr[3:2]] <= pwdata;
      end
   end

   assign v_in = {v_ff[5:0], start && !busy};

   always_comb begin
      s_in[LANE_NEAR] = req_near_sample;
      s_in[LANE_FAR]  = req_far_sample;
      for (int ln = 0; ln < LANES; ln++) begin
         sq_in[ln]   = s_ff[ln] * s_ff[ln];
         cube_in[ln] = sq_ff[ln] * s2_ff[ln];
         p1_in[ln]   = coef_ff[ln][1] * $signed({1'b0, s2_ff[ln]});
         p2_in[ln]   = coef_ff[ln][2] * $signed({1'b0, sq_ff[ln]});
         p3_in[ln]   = coef_ff[ln][3] * $signed({1'b0, cube_ff[ln]});
         t1[ln] = USE1 ? ((SUM_W'(p1_ff[ln]) + HALF1) >>> K1) : SUM_W'(0);
         t2[ln] = USE2 ? ((SUM_W'(p2_ff[ln]) + HALF2) >>> K2) : SUM_W'(0);
         t3[ln] = USE3 ? ((SUM_W'(p3_ff[ln]) + HALF3) >>> K3) : SUM_W'(0);
         part_in[ln] = SUM_W'(coef_ff[ln][0]) + t1[ln] + t2[ln];
         dist_in[ln] = part_ff[ln] + t3[ln];
      end
   end

   always_comb begin
      pair_sum = dist_ff[LANE_NEAR] + dist_ff[LANE_FAR];
      if (dist_ff[LANE_FAR] < FAR_LIMIT) begin
         sel_in = dist_ff[LANE_FAR];
      end else if (dist_ff[LANE_NEAR] > NEAR_LIMIT) begin
         sel_in = dist_ff[LANE_NEAR];
      end else begin
         sel_in = pair_sum >>> 1;
      end
      if (sel_ff > DIST_MAX) begin
         out_in = DIST_MAX[COEF_W-1:0];
      end else if (sel_ff < DIST_MIN) begin
         out_in = DIST_MIN[COEF_W-1:0];
      end else begin
         out_in = sel_ff[COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int ln = 0; ln < LANES; ln++) begin
         s_ff[ln]    <= s_in[ln];
         s2_ff[ln]   <= s_ff[ln];
         sq_ff[ln]   <= sq_in[ln];
         cube_ff[ln] <= cube_in[ln];
         p1_ff[ln]   <= p1_in[ln];
         p2_ff[ln]   <= p2_in[ln];
         p3_ff[ln]   <= p3_in[ln];
         part_ff[ln] <= part_in[ln];
         dist_ff[ln] <= dist_in[ln];
      end
      sel_ff <= sel_in;
      out_ff <= out_in;
   end

   assign rsp_valid    = v_ff[6];
   assign rsp_distance = out_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_valid)
      else $error("accepted word did not produce a result after seven cycles");

   a_far_pick: assert property (@(posedge clock) disable iff (reset)
      (v_ff[4] && dist_ff[LANE_FAR] < FAR_LIMIT) |=> (sel_ff == $past(dist_ff[LANE_FAR])))
      else $error("far distance below limit was not selected");

   a_clamp_pass: assert property (@(posedge clock) disable iff (reset)
      (v_ff[5] && sel_ff <= DIST_MAX && sel_ff >= DIST_MIN)
      |=> (rsp_distance == $past(sel_ff[COEF_W-1:0])))
      else $error("in-range distance altered by saturation");
endmodule
